// ===== sv/ialu_pkg.sv =====
package ialu_pkg;

	localparam int unsigned DataW = 64;

	// opcode encodings
	localparam logic [2:0] OP_ADDU = 3'd0;
	localparam logic [2:0] OP_ADDS = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MULU = 3'd3;
	localparam logic [2:0] OP_MULS = 3'd4;
	localparam logic [2:0] OP_DIVU = 3'd5;

	// positions in the flag register
	localparam int unsigned FLAG_Z = 0;
	localparam int unsigned FLAG_N = 1;
	localparam int unsigned FLAG_C = 2;
	localparam int unsigned FLAG_V = 3;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [DataW-1:0] operand_a;
		logic [DataW-1:0] operand_b;
	} ialu_req_t;

	typedef struct packed {
		logic [DataW-1:0] result_value;
		logic             zero_flag;
		logic             negative_flag;
		logic             carry_flag;
		logic             overflow_flag;
	} ialu_rsp_t;

	// finished operation handed from the sequencer to the output side
	typedef struct packed {
		logic             valid;
		logic             upd;
		logic [DataW-1:0] result;
		logic [3:0]       flags;
	} ialu_done_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_MUL,
		S_MFIXA,
		S_MFIXB,
		S_DIV,
		S_FIN
	} ialu_state_t;

endpackage

// ===== sv/ialu_seq.sv =====
module ialu_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ialu_pkg::ialu_req_t   req,
	output logic                  idle,
	input  logic                  ack,
	output ialu_pkg::ialu_done_t  done
);
	import ialu_pkg::*;

	localparam int unsigned CntW = $clog2(DataW);

	ialu_state_t state_q, state_d;
	logic [2:0]       op_q;
	logic [DataW-1:0] a_q, b_q, hi_q, lo_q;
	logic [CntW-1:0]  cnt_q;
	logic             nop_q, c_q, v_q;
	logic             last_iter;

	// shared adder / subtractor
	logic [DataW:0]   add_x, add_y;
	logic             add_sub;
	logic [DataW+1:0] add_sum;

	assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(DataW+1){add_sub}}}
		+ (DataW+2)'(add_sub);
	assign last_iter = (cnt_q == {CntW{1'b1}});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.opcode)
						OP_ADDU, OP_ADDS, OP_SUB: state_d = S_ADD;
						OP_MULU, OP_MULS:         state_d = S_MUL;
						OP_DIVU: begin
							state_d = (req.operand_b == '0) ? S_FIN : S_DIV;
						end
						default:                  state_d = S_FIN;
					endcase
				end
			end
			S_ADD:   state_d = S_FIN;
			S_MUL: begin
				if (last_iter) state_d = (op_q == OP_MULS) ? S_MFIXA : S_FIN;
			end
			S_MFIXA: state_d = S_MFIXB;
			S_MFIXB: state_d = S_FIN;
			S_DIV: begin
				if (last_iter) state_d = S_FIN;
			end
			S_FIN: begin
				if (ack) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// adder operand selection and status
	always_comb begin
		add_x   = {1'b0, a_q};
		add_y   = {1'b0, b_q};
		add_sub = 1'b0;
		idle    = 1'b0;
		case (state_q)
			S_IDLE: idle = 1'b1;
			S_ADD:  add_sub = (op_q == OP_SUB);
			S_MUL: begin
				add_x = {1'b0, hi_q};
				add_y = lo_q[0] ? {1'b0, a_q} : '0;
			end
			S_MFIXA: begin
				add_x   = {1'b0, hi_q};
				add_y   = a_q[DataW-1] ? {1'b0, b_q} : '0;
				add_sub = 1'b1;
			end
			S_MFIXB: begin
				add_x   = {1'b0, hi_q};
				add_y   = b_q[DataW-1] ? {1'b0, a_q} : '0;
				add_sub = 1'b1;
			end
			S_DIV: begin
				add_x   = {hi_q, lo_q[DataW-1]};
				add_sub = 1'b1;
			end
			default: ;
		endcase
	end

	// finished result and flags
	always_comb begin
		done.valid          = (state_q == S_FIN);
		done.upd            = !nop_q;
		done.result         = nop_q ? '0 : lo_q;
		done.flags          = '0;
		done.flags[FLAG_Z]  = (lo_q == '0);
		done.flags[FLAG_N]  = lo_q[DataW-1];
		done.flags[FLAG_C]  = c_q;
		case (op_q)
			OP_MULU: done.flags[FLAG_V] = (hi_q != '0);
			OP_MULS: done.flags[FLAG_V] = (hi_q != {DataW{lo_q[DataW-1]}});
			OP_DIVU: done.flags[FLAG_V] = 1'b0;
			default: done.flags[FLAG_V] = v_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL || state_q == S_DIV) cnt_q <= cnt_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q  <= req.opcode;
					a_q   <= req.operand_a;
					b_q   <= req.operand_b;
					hi_q  <= '0;
					c_q   <= 1'b0;
					v_q   <= 1'b0;
					nop_q <= (req.opcode > OP_DIVU)
						|| (req.opcode == OP_DIVU && req.operand_b == '0);
					case (req.opcode)
						OP_MULU, OP_MULS: lo_q <= req.operand_b;
						OP_DIVU:          lo_q <= req.operand_a;
						default:          lo_q <= '0;
					endcase
				end
			end
			S_ADD: begin
				lo_q <= add_sum[DataW-1:0];
				c_q  <= (op_q == OP_ADDU) ? add_sum[DataW]
					: ((op_q == OP_SUB) ? !add_sum[DataW+1] : 1'b0);
				if (op_q == OP_SUB) begin
					v_q <= (a_q[DataW-1] != b_q[DataW-1])
						&& (add_sum[DataW-1] != a_q[DataW-1]);
				end else begin
					v_q <= (a_q[DataW-1] == b_q[DataW-1])
						&& (add_sum[DataW-1] != a_q[DataW-1]);
				end
			end
			// shift-add step: carry into hi, product bits move down into lo
			S_MUL: begin
				hi_q <= add_sum[DataW:1];
				lo_q <= {add_sum[0], lo_q[DataW-1:1]};
			end
			// signed correction of the high half
			S_MFIXA, S_MFIXB: hi_q <= add_sum[DataW-1:0];
			// restoring divide step: remainder in hi, quotient shifts into lo
			S_DIV: begin
				hi_q <= add_sum[DataW+1] ? add_sum[DataW-1:0] : add_x[DataW-1:0];
				lo_q <= {lo_q[DataW-2:0], add_sum[DataW+1]};
			end
			default: ;
		endcase
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && idle |=> !idle)
		else $error("sequencer still idle after start");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |-> cnt_q == '0)
		else $error("iteration count not back to zero");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && op_q == OP_DIVU && b_q == '0)
			|-> (!done.upd && done.result == '0))
		else $error("divide by zero updates flags or result");

endmodule

// ===== sv/integer_alu_with_flags_top.sv =====
// 64-bit integer ALU with zero, negative, carry and overflow flags. One
// request at a time goes through a single shared 66-bit adder/subtractor
// under a small sequencer that handles add and subtract, unsigned multiply
// (shift-add, one bit per cycle), divide (restoring, one quotient bit per
// cycle) and signed multiply (two extra correction passes for the high half);
// a divide by zero or an unused opcode goes straight to the result. A
// finished result sits in an output register so the next request can be
// taken while it waits; divide by zero and unused opcodes return 0 and report
// the previous flags unchanged.
module integer_alu_with_flags_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ialu_pkg::ialu_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ialu_pkg::ialu_rsp_t rsp
);
	import ialu_pkg::*;

	ialu_done_t core_done;
	logic       core_idle;
	logic       core_take;
	logic [3:0] flag_q;
	logic [3:0] flags_out;
	logic       rsp_valid_q;
	ialu_rsp_t  rsp_q;

	ialu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_valid),
		.req    (req),
		.idle   (core_idle),
		.ack    (core_take),
		.done   (core_done)
	);

	assign req_ready = core_idle;
	assign core_take = core_done.valid && (!rsp_valid_q || rsp_ready);
	assign flags_out = core_done.upd ? core_done.flags : flag_q;

	// flag register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (core_take) begin
				rsp_valid_q <= 1'b1;
				flag_q      <= flags_out;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (core_take) begin
			rsp_q.result_value  <= core_done.result;
			rsp_q.zero_flag     <= flags_out[FLAG_Z];
			rsp_q.negative_flag <= flags_out[FLAG_N];
			rsp_q.carry_flag    <= flags_out[FLAG_C];
			rsp_q.overflow_flag <= flags_out[FLAG_V];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!core_take |=> $stable(flag_q))
		else $error("flags changed without a result transfer");

	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		core_take |=> (rsp.zero_flag == flag_q[FLAG_Z]
			&& rsp.negative_flag == flag_q[FLAG_N]
			&& rsp.carry_flag == flag_q[FLAG_C]
			&& rsp.overflow_flag == flag_q[FLAG_V]))
		else $error("reported flags differ from flag register");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

endmodule

// ===== sim/integer_alu_with_flags_top_tb.sv =====
module integer_alu_with_flags_top_tb;
	import ialu_pkg::*;

	// opcodes the block leaves unused
	localparam logic [2:0] OP_RSV6 = 3'd6;
	localparam logic [2:0] OP_RSV7 = 3'd7;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam int unsigned RANDOM_OPS = 830;
	localparam int unsigned LONG_HOLD  = 300;

	typedef struct {
		ialu_req_t   op;
		int unsigned gap;
		bit          drain;
	} pending_op_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	ialu_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	ialu_rsp_t rsp;

	pending_op_t pending_ops[$];
	ialu_rsp_t   expected_rsps[$];
	logic [3:0]  flag_reg;
	int unsigned sent_count;
	int unsigned rsp_seen = 0;
	int unsigned err_count = 0;
	int unsigned gap_left;
	bit          gap_loaded;
	int unsigned stall_left;
	int unsigned calm_left;
	int unsigned hold_left;

	integer_alu_with_flags_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, a few long
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	// operand patterns biased toward edges and sign boundaries
	function automatic logic [63:0] pick_operand();
		logic [63:0] v;
		case ($urandom_range(0, 10))
			0: v = '0;
			1: v = ALL_ONES;
			2: v = MIN_NEG;
			3: v = MAX_POS;
			4: v = 64'($urandom_range(1, 15));
			5: v = -64'($urandom_range(1, 15));
			6: v = {32'h0, $urandom};
			7: v = 64'h1 << $urandom_range(0, 63);
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [2:0] pick_opcode();
		logic [2:0] op;
		case ($urandom_range(0, 19))
			0, 1, 2:    op = OP_ADDU;
			3, 4, 5:    op = OP_ADDS;
			6, 7, 8:    op = OP_SUB;
			9, 10, 11:  op = OP_MULU;
			12, 13, 14: op = OP_MULS;
			15, 16, 17: op = OP_DIVU;
			18:         op = OP_RSV6;
			default:    op = OP_RSV7;
		endcase
		return op;
	endfunction

	// expected response for one accepted request; updates the flag register
	function automatic ialu_rsp_t alu_predict(ialu_req_t q);
		logic [63:0]         a;
		logic [63:0]         b;
		logic [63:0]         r;
		logic [64:0]         sum;
		logic [127:0]        uprod;
		logic signed [127:0] sprod;
		logic [3:0]          f;
		bit                  upd;
		ialu_rsp_t           o;
		a = q.operand_a;
		b = q.operand_b;
		r = '0;
		f = '0;
		upd = 1'b1;
		case (q.opcode)
			OP_ADDU, OP_ADDS: begin
				sum = {1'b0, a} + {1'b0, b};
				r = sum[63:0];
				f[FLAG_C] = (q.opcode == OP_ADDU) && sum[64];
				f[FLAG_V] = (a[63] == b[63]) && (r[63] != a[63]);
			end
			OP_SUB: begin
				r = a - b;
				f[FLAG_C] = a < b;
				f[FLAG_V] = (a[63] != b[63]) && (r[63] != a[63]);
			end
			OP_MULU: begin
				uprod = {64'h0, a} * {64'h0, b};
				r = uprod[63:0];
				f[FLAG_V] = uprod[127:64] != 64'h0;
			end
			OP_MULS: begin
				sprod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
				r = sprod[63:0];
				f[FLAG_V] = sprod[127:64] != {64{sprod[63]}};
			end
			OP_DIVU: begin
				// divide by zero leaves the flags alone
				if (b != 64'h0)
					r = a / b;
				else
					upd = 1'b0;
			end
			default: begin
				upd = 1'b0;
			end
		endcase
		if (upd) begin
			f[FLAG_Z] = r == 64'h0;
			f[FLAG_N] = r[63];
			flag_reg = f;
		end
		o.result_value  = r;
		o.zero_flag     = flag_reg[FLAG_Z];
		o.negative_flag = flag_reg[FLAG_N];
		o.carry_flag    = flag_reg[FLAG_C];
		o.overflow_flag = flag_reg[FLAG_V];
		return o;
	endfunction

	task automatic queue_op(logic [2:0] op, logic [63:0] a, logic [63:0] b,
			int unsigned gap, bit drain);
		pending_op_t p;
		p.op.opcode    = op;
		p.op.operand_a = a;
		p.op.operand_b = b;
		p.gap          = gap;
		p.drain        = drain;
		pending_ops.push_back(p);
	endtask

	// compare one response transfer against the oldest expectation
	task automatic check_rsp(ialu_rsp_t got);
		ialu_rsp_t want;
		if (expected_rsps.size() == 0) begin
			$error("response with nothing expected: result_value %h", got.result_value);
			err_count++;
			return;
		end
		want = expected_rsps.pop_front();
		if (got.result_value !== want.result_value) begin
			$error("result_value: expected %h, got %h", want.result_value, got.result_value);
			err_count++;
		end
		if (got.zero_flag !== want.zero_flag) begin
			$error("zero_flag: expected %b, got %b", want.zero_flag, got.zero_flag);
			err_count++;
		end
		if (got.negative_flag !== want.negative_flag) begin
			$error("negative_flag: expected %b, got %b", want.negative_flag,
				got.negative_flag);
			err_count++;
		end
		if (got.carry_flag !== want.carry_flag) begin
			$error("carry_flag: expected %b, got %b", want.carry_flag, got.carry_flag);
			err_count++;
		end
		if (got.overflow_flag !== want.overflow_flag) begin
			$error("overflow_flag: expected %b, got %b", want.overflow_flag,
				got.overflow_flag);
			err_count++;
		end
	endtask

	// request driver: waits out each item's gap, may hold until all results are back
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			flag_reg = '0;
			sent_count = 0;
			gap_loaded = 1'b0;
			gap_left = 0;
		end else begin
			busy = req_valid;
			if (req_valid && req_ready) begin
				expected_rsps.push_back(alu_predict(req));
				sent_count++;
				busy = 1'b0;
			end
			if (!busy && pending_ops.size() != 0) begin
				if (!gap_loaded) begin
					gap_left = pending_ops[0].gap;
					gap_loaded = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else if (!pending_ops[0].drain || sent_count == rsp_seen) begin
					req <= pending_ops[0].op;
					pending_ops.pop_front();
					gap_loaded = 1'b0;
					busy = 1'b1;
				end
			end
			req_valid <= busy;
		end
	end

	// response monitor with random backpressure and two long holds
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
			calm_left = 0;
			hold_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				check_rsp(rsp);
				rsp_seen <= rsp_seen + 1;
				if (rsp_seen + 1 == 40 || rsp_seen + 1 == 520)
					hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (calm_left != 0)
					calm_left--;
				else if ($urandom_range(0, 199) == 0)
					calm_left = $urandom_range(50, 200);
				else if ($urandom_range(0, 2) == 0)
					stall_left = idle_len();
			end
		end
	end

	// stimulus and end of run
	initial begin
		// add: zero, wrap with carry, signed overflow both ways
		queue_op(OP_ADDU, 64'h0, 64'h0, 0, 1'b0);
		queue_op(OP_ADDU, ALL_ONES, 64'h1, 0, 1'b0);
		queue_op(OP_ADDU, MIN_NEG, MIN_NEG, 0, 1'b0);
		queue_op(OP_ADDU, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_op(OP_ADDS, MAX_POS, 64'h1, 0, 1'b0);
		queue_op(OP_ADDS, MIN_NEG, ALL_ONES, 0, 1'b0);
		queue_op(OP_ADDS, ALL_ONES, 64'h1, 0, 1'b0);
		// subtract: borrow, overflow, equal operands
		queue_op(OP_SUB, 64'h0, 64'h1, 0, 1'b0);
		queue_op(OP_SUB, MIN_NEG, 64'h1, 0, 1'b0);
		queue_op(OP_SUB, MAX_POS, ALL_ONES, 0, 1'b0);
		queue_op(OP_SUB, ALL_ONES, ALL_ONES, 0, 1'b0);
		// multiply: full-width overflow, low half zero, signed corners
		queue_op(OP_MULU, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_op(OP_MULU, 64'h1_0000_0000, 64'h1_0000_0000, 0, 1'b0);
		queue_op(OP_MULU, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 0, 1'b0);
		queue_op(OP_MULS, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_op(OP_MULS, MIN_NEG, ALL_ONES, 0, 1'b0);
		queue_op(OP_MULS, MIN_NEG, 64'h1, 0, 1'b0);
		queue_op(OP_MULS, MAX_POS, 64'h2, 0, 1'b0);
		// divide: by zero keeps flags, quotient zero, largest quotient
		queue_op(OP_DIVU, ALL_ONES, 64'h0, 0, 1'b0);
		queue_op(OP_DIVU, ALL_ONES, 64'h1, 0, 1'b0);
		queue_op(OP_DIVU, 64'h5, 64'h7, 0, 1'b0);
		queue_op(OP_DIVU, MIN_NEG, 64'h2, 0, 1'b0);
		queue_op(OP_SUB, 64'h0, 64'h1, 0, 1'b0);
		// unused opcodes return zero and keep flags
		queue_op(OP_RSV6, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_op(OP_RSV7, {$urandom, $urandom}, {$urandom, $urandom}, 0, 1'b0);

		for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
			int unsigned gap;
			bit          drain;
			// burst stretches with no sender idling
			if ((i >= 100 && i < 160) || (i >= 700 && i < 760))
				gap = 0;
			else
				gap = idle_len();
			drain = (i == 300 || i == 600);
			queue_op(pick_opcode(), pick_operand(), pick_operand(), gap, drain);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_valid)
			@(negedge clk);
		while (expected_rsps.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		if (err_count == 0 && expected_rsps.size() == 0) begin
			$display("integer_alu_with_flags_top regression: pass");
		end else begin
			$display("integer_alu_with_flags_top regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("integer_alu_with_flags_top regression: fail");
		$finish;
	end

endmodule
